[rtl/agcs_pkg.sv]
// Package: shared constants, field widths and controller/datapath command types.
package agcs_pkg;

	localparam int MAX_BOXES_DEF = 64;

	localparam int SLOT_W = 6;
	localparam int POS_W = 16;
	localparam int SIZE_W = 12;
	localparam int VEL_W = 24;
	localparam int FRAC_W = 13;
	localparam int GRAV_W = 17;
	localparam int TERM_W = 23;
	localparam int TOUCH_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 23;

	localparam int IN_DATA_W = 144;
	localparam int OUT_DATA_W = 112;

	// working widths inside the step
	localparam int WPOS_W = 20;
	localparam int WVY_W = 25;
	localparam int SUM_W = 26;
	localparam int DELTA_W = 14;

	localparam int PX_SHIFT = 12;
	localparam logic [PX_SHIFT-1:0] PX_MASK = '1;

	localparam logic [GRAV_W-1:0] GRAVITY_RST = GRAV_W'(1400);
	localparam logic [TERM_W-1:0] TERMINAL_RST = TERM_W'(6 * 4096);

	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TERMINAL = 1'b1;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	localparam int T_RIGHT = 0;
	localparam int T_LEFT = 1;
	localparam int T_FLOOR = 2;
	localparam int T_CEIL = 3;

	localparam logic [1:0] PH_X = 2'd0;
	localparam logic [1:0] PH_Y = 2'd1;
	localparam logic [1:0] PH_G = 2'd2;

	typedef struct packed {
		logic       load;     // write the accepted load item into the table
		logic       latch;    // capture the accepted step item
		logic       vel;      // gravity and terminal clamp
		logic       split;    // split whole pixels, move in X
		logic       add_dy;   // move in Y
		logic       proc;     // table entry read last cycle is valid to check
		logic [1:0] phase;    // which walk the entry check belongs to
		logic       fin;      // cancel speeds, load the output register
	} cmd_t;

	typedef struct packed {
		logic out_free;       // output register empty or being taken
	} status_t;

endpackage

[rtl/aabb_gravity_collision_step_top.sv]
// Top level: gravity step with axis-separated box collision against a box table.
// Latency: a load item takes effect in the cycle it is accepted and gives no result.
// A step item gives its result after three walks over the box table; the final state
// holds the result back while the output register is still full and not being taken.
// Throughput: one step item at a time; load items are taken every cycle while idle.
// Reset (arst_n low, asynchronous): all slots invalid, registers at defaults.
module aabb_gravity_collision_step_top #(
	parameter int MAX_BOXES = agcs_pkg::MAX_BOXES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// slot_index, box_left, box_top, box_width, box_height, solid_visible,
	// vel_x, vel_y, frac_x, frac_y, zero pad
	input  logic [agcs_pkg::IN_DATA_W-1:0]    s_tdata,
	// kind
	input  logic                              s_tuser,
	// result items
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// new_left, new_top, new_vel_x, new_vel_y, new_frac_x, new_frac_y,
	// touch_flags, zero pad
	output logic [agcs_pkg::OUT_DATA_W-1:0]   m_tdata,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [agcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [agcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

	agcs_pkg::cmd_t cmd;
	agcs_pkg::status_t status;
	logic [AW-1:0] rd_addr;

	// sequence: accept, velocity, split and X move, X walk, Y move, Y walk,
	// ground walk, cancel and hand the item to the output register
	agcs_ctrl #(.MAX_BOXES(MAX_BOXES), .AW(AW)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_kind(s_tuser),
		.in_ready(s_tready),
		.status(status),
		.cmd(cmd),
		.rd_addr(rd_addr)
	);

	// table, arithmetic and the output register that decouples the result side
	agcs_dp #(.MAX_BOXES(MAX_BOXES), .AW(AW)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(s_tdata),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.status(status),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(m_tdata)
	);

`ifndef NO_ASSERTIONS
	// a step item blocks further input while it works
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == agcs_pkg::KIND_STEP) |=> !s_tready)
		else $error("input still ready after step item");

	// a load item never blocks the input
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == agcs_pkg::KIND_LOAD) |=> s_tready)
		else $error("input blocked after load item");

	// a result appears only at the end of a step in progress
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a step in progress");
`endif

endmodule

[rtl/agcs_ctrl.sv]
// Controller: sequences load, velocity update, three table walks and result.
module agcs_ctrl #(
	parameter int MAX_BOXES = agcs_pkg::MAX_BOXES_DEF,
	parameter int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_kind,
	output logic                  in_ready,
	input  agcs_pkg::status_t     status,
	output agcs_pkg::cmd_t        cmd,
	output logic [AW-1:0]         rd_addr
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_VEL = 3'd1;
	localparam logic [2:0] S_SPLIT = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_DY = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;

	localparam logic [AW:0] LAST = (AW+1)'(MAX_BOXES);

	logic [2:0] state_q;
	logic [1:0] phase_q;
	logic [AW:0] cnt_q;
	logic accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign rd_addr = (cnt_q < LAST) ? cnt_q[AW-1:0] : '0;

	always_comb begin
		cmd = '0;
		cmd.load = accept && (in_kind == agcs_pkg::KIND_LOAD);
		cmd.latch = accept && (in_kind == agcs_pkg::KIND_STEP);
		cmd.vel = (state_q == S_VEL);
		cmd.split = (state_q == S_SPLIT);
		cmd.add_dy = (state_q == S_DY);
		cmd.proc = (state_q == S_WALK) && (cnt_q != '0);
		cmd.phase = phase_q;
		cmd.fin = (state_q == S_FIN) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= agcs_pkg::PH_X;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.latch) state_q <= S_VEL;
				end
				S_VEL: state_q <= S_SPLIT;
				S_SPLIT: begin
					state_q <= S_WALK;
					phase_q <= agcs_pkg::PH_X;
					cnt_q <= '0;
				end
				S_WALK: begin
					if (cnt_q == LAST) begin
						cnt_q <= '0;
						unique case (phase_q)
							agcs_pkg::PH_X: state_q <= S_DY;
							agcs_pkg::PH_Y: phase_q <= agcs_pkg::PH_G;
							default: state_q <= S_FIN;
						endcase
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DY: begin
					state_q <= S_WALK;
					phase_q <= agcs_pkg::PH_Y;
				end
				S_FIN: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/agcs_dp.sv]
// Datapath: box table, configuration registers, motion arithmetic, output register.
module agcs_dp #(
	parameter int MAX_BOXES = agcs_pkg::MAX_BOXES_DEF,
	parameter int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [agcs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [agcs_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic [agcs_pkg::IN_DATA_W-1:0]        in_data,
	input  agcs_pkg::cmd_t                        cmd,
	input  logic [AW-1:0]                         rd_addr,
	output agcs_pkg::status_t                     status,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [agcs_pkg::OUT_DATA_W-1:0]       out_data
);

	localparam int WP = agcs_pkg::WPOS_W;
	localparam int CMPW = AW + 8;

	typedef struct packed {
		logic signed [agcs_pkg::POS_W:0] hy;
		logic signed [agcs_pkg::POS_W:0] hx;
		logic signed [agcs_pkg::POS_W-1:0] ly;
		logic signed [agcs_pkg::POS_W-1:0] lx;
	} entry_t;

	// input fields
	logic [agcs_pkg::SLOT_W-1:0] f_slot;
	logic signed [agcs_pkg::POS_W-1:0] f_left, f_top;
	logic [agcs_pkg::SIZE_W-1:0] f_w, f_h;
	logic f_solid;
	logic signed [agcs_pkg::VEL_W-1:0] f_vx, f_vy;
	logic signed [agcs_pkg::FRAC_W-1:0] f_fx, f_fy;

	assign f_slot = in_data[5:0];
	assign f_left = in_data[21:6];
	assign f_top = in_data[37:22];
	assign f_w = in_data[49:38];
	assign f_h = in_data[61:50];
	assign f_solid = in_data[62];
	assign f_vx = in_data[86:63];
	assign f_vy = in_data[110:87];
	assign f_fx = in_data[123:111];
	assign f_fy = in_data[136:124];

	// configuration
	logic signed [agcs_pkg::GRAV_W-1:0] grav_q;
	logic [agcs_pkg::TERM_W-1:0] term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= agcs_pkg::GRAVITY_RST;
			term_q <= agcs_pkg::TERMINAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				agcs_pkg::REG_GRAVITY: grav_q <= cfg_data[agcs_pkg::GRAV_W-1:0];
				agcs_pkg::REG_TERMINAL: term_q <= cfg_data[agcs_pkg::TERM_W-1:0];
				default: ;
			endcase
		end
	end

	// box table
	entry_t mem [MAX_BOXES];
	logic [MAX_BOXES-1:0] valid_q;
	entry_t rd_s1;
	logic rdv_s1;
	logic [AW-1:0] idx_s1;
	logic slot_ok;
	entry_t wr_entry;

	assign slot_ok = CMPW'(f_slot) < CMPW'(MAX_BOXES);
	assign wr_entry.lx = f_left;
	assign wr_entry.ly = f_top;
	assign wr_entry.hx = (agcs_pkg::POS_W+1)'(f_left) + $signed({5'b0, f_w});
	assign wr_entry.hy = (agcs_pkg::POS_W+1)'(f_top) + $signed({5'b0, f_h});

	always_ff @(posedge clk) begin
		if (cmd.load && slot_ok) mem[AW'(f_slot)] <= wr_entry;
		rd_s1 <= mem[rd_addr];
		idx_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdv_s1 <= 1'b0;
		end else begin
			if (cmd.load && slot_ok) valid_q[AW'(f_slot)] <= f_solid;
			rdv_s1 <= valid_q[rd_addr];
		end
	end

	// step state
	logic [agcs_pkg::SLOT_W-1:0] slot_q;
	logic signed [WP-1:0] left_q, top_q;
	logic [agcs_pkg::SIZE_W-1:0] w_q, h_q;
	logic signed [agcs_pkg::VEL_W-1:0] vx_q, vyin_q;
	logic signed [agcs_pkg::WVY_W-1:0] vy_q;
	logic signed [agcs_pkg::FRAC_W-1:0] fx_q, fy_q;
	logic signed [agcs_pkg::DELTA_W-1:0] dx_q, dy_q;
	logic [agcs_pkg::TOUCH_W-1:0] hit_q;

	// velocity
	logic signed [agcs_pkg::WVY_W-1:0] vy_sum, term_s;
	assign vy_sum = agcs_pkg::WVY_W'(vyin_q) + agcs_pkg::WVY_W'(grav_q);
	assign term_s = $signed({2'b0, term_q});

	// whole pixel split, truncating toward zero
	logic signed [agcs_pkg::SUM_W-1:0] sx, sy, sx_b, sy_b;
	logic signed [agcs_pkg::DELTA_W-1:0] dx, dy;
	logic signed [agcs_pkg::SUM_W-1:0] rx, ry;
	assign sx = agcs_pkg::SUM_W'(fx_q) + agcs_pkg::SUM_W'(vx_q);
	assign sy = agcs_pkg::SUM_W'(fy_q) + agcs_pkg::SUM_W'(vy_q);
	assign sx_b = sx + (sx[agcs_pkg::SUM_W-1] ?
		agcs_pkg::SUM_W'(agcs_pkg::PX_MASK) : '0);
	assign sy_b = sy + (sy[agcs_pkg::SUM_W-1] ?
		agcs_pkg::SUM_W'(agcs_pkg::PX_MASK) : '0);
	assign dx = agcs_pkg::DELTA_W'(sx_b >>> agcs_pkg::PX_SHIFT);
	assign dy = agcs_pkg::DELTA_W'(sy_b >>> agcs_pkg::PX_SHIFT);
	assign rx = sx - (agcs_pkg::SUM_W'(dx) <<< agcs_pkg::PX_SHIFT);
	assign ry = sy - (agcs_pkg::SUM_W'(dy) <<< agcs_pkg::PX_SHIFT);

	// entry check
	logic signed [WP-1:0] r_e, b_e, lx_e, ly_e, hx_e, hy_e, w_e, h_e, gap;
	logic hit_ok, ovl_x, ovl_y, touch;
	assign w_e = $signed({{(WP-agcs_pkg::SIZE_W){1'b0}}, w_q});
	assign h_e = $signed({{(WP-agcs_pkg::SIZE_W){1'b0}}, h_q});
	assign r_e = left_q + w_e;
	assign b_e = top_q + h_e;
	assign lx_e = WP'(rd_s1.lx);
	assign ly_e = WP'(rd_s1.ly);
	assign hx_e = WP'(rd_s1.hx);
	assign hy_e = WP'(rd_s1.hy);
	assign gap = ly_e - b_e;
	assign hit_ok = cmd.proc && rdv_s1 && (CMPW'(idx_s1) != CMPW'(slot_q));
	assign ovl_x = (r_e > lx_e) && (hx_e > left_q);
	assign ovl_y = (b_e > ly_e) && (hy_e > top_q);
	assign touch = hit_ok && ovl_x && ovl_y;

	// output saturation
	logic signed [agcs_pkg::POS_W-1:0] sat_l, sat_t;
	logic signed [agcs_pkg::VEL_W-1:0] sat_vy, o_vx, o_vy;
	logic signed [agcs_pkg::FRAC_W-1:0] o_fx, o_fy;
	logic floor_cancel;

	always_comb begin
		if (left_q > WP'(32767)) sat_l = 16'sh7FFF;
		else if (left_q < -WP'(32768)) sat_l = 16'sh8000;
		else sat_l = left_q[agcs_pkg::POS_W-1:0];
		if (top_q > WP'(32767)) sat_t = 16'sh7FFF;
		else if (top_q < -WP'(32768)) sat_t = 16'sh8000;
		else sat_t = top_q[agcs_pkg::POS_W-1:0];
		if (vy_q > agcs_pkg::WVY_W'(24'sh7FFFFF)) sat_vy = 24'sh7FFFFF;
		else if (vy_q < agcs_pkg::WVY_W'(-25'sd8388608)) sat_vy = 24'sh800000;
		else sat_vy = vy_q[agcs_pkg::VEL_W-1:0];
		floor_cancel = hit_q[agcs_pkg::T_CEIL] ||
			(hit_q[agcs_pkg::T_FLOOR] && (vy_q > 0));
		o_vy = floor_cancel ? '0 : sat_vy;
		o_fy = floor_cancel ? '0 : fy_q;
		o_vx = (hit_q[agcs_pkg::T_LEFT] || hit_q[agcs_pkg::T_RIGHT]) ? '0 : vx_q;
		o_fx = (hit_q[agcs_pkg::T_LEFT] || hit_q[agcs_pkg::T_RIGHT]) ? '0 : fx_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			slot_q <= f_slot;
			left_q <= WP'(f_left);
			top_q <= WP'(f_top);
			w_q <= f_w;
			h_q <= f_h;
			vx_q <= f_vx;
			vyin_q <= f_vy;
			fx_q <= f_fx;
			fy_q <= f_fy;
		end
		if (cmd.vel) vy_q <= (vy_sum > term_s) ? term_s : vy_sum;
		if (cmd.split) begin
			dx_q <= dx;
			dy_q <= dy;
			fx_q <= agcs_pkg::FRAC_W'(rx);
			fy_q <= agcs_pkg::FRAC_W'(ry);
			left_q <= left_q + WP'(dx);
		end
		if (cmd.add_dy) top_q <= top_q + WP'(dy_q);
		if (touch && (cmd.phase == agcs_pkg::PH_X) && (dx_q != '0)) begin
			left_q <= dx_q[agcs_pkg::DELTA_W-1] ? hx_e : (lx_e - w_e);
		end
		if (touch && (cmd.phase == agcs_pkg::PH_Y) && (dy_q != '0)) begin
			top_q <= dy_q[agcs_pkg::DELTA_W-1] ? hy_e : (ly_e - h_e);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else if (cmd.latch) begin
			hit_q <= '0;
		end else begin
			if (touch && (cmd.phase == agcs_pkg::PH_X) && (dx_q != '0)) begin
				if (dx_q[agcs_pkg::DELTA_W-1]) hit_q[agcs_pkg::T_LEFT] <= 1'b1;
				else hit_q[agcs_pkg::T_RIGHT] <= 1'b1;
			end
			if (touch && (cmd.phase == agcs_pkg::PH_Y) && (dy_q != '0)) begin
				if (dy_q[agcs_pkg::DELTA_W-1]) hit_q[agcs_pkg::T_CEIL] <= 1'b1;
				else hit_q[agcs_pkg::T_FLOOR] <= 1'b1;
			end
			if (hit_ok && (cmd.phase == agcs_pkg::PH_G) && ovl_x && !vy_q[agcs_pkg::WVY_W-1]
				&& (gap >= 0) && (gap <= WP'(1))) begin
				hit_q[agcs_pkg::T_FLOOR] <= 1'b1;
			end
		end
	end

	// output register
	logic out_valid_q;
	logic [agcs_pkg::OUT_DATA_W-1:0] out_data_q;

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_data_q <= {2'b0, hit_q, o_fy, o_fx, o_vy, o_vx, sat_t, sat_l};
		end
	end

endmodule
